/* sv/pem_pkg.sv */
package pem_pkg;

    localparam int KWH_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int WATTS_W    = 22;
    localparam int PPER_W     = 20;
    localparam int SILENT_W   = 8;
    localparam int SECS_W     = 12;
    localparam int PPK_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W      = 22;

    localparam logic [DIV_W-1:0]    WATT_SEC_PER_KWH  = 22'd3600000;
    localparam logic [WATTS_W-1:0]  WATTS_MAX         = 22'h3FFFFF;
    localparam logic [PPER_W-1:0]   PERIOD_PULSES_MAX = 20'hFFFFF;
    localparam logic [SILENT_W-1:0] SILENT_MAX        = 8'd255;
    localparam logic [SILENT_W-1:0] MISS_THRESHOLD    = 8'd10;
    localparam logic [SECS_W-1:0]   SECS_RESET        = 12'd30;
    localparam logic [PPK_W-1:0]    PPK_RESET         = 16'd10000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PULSE  = 2'd0,
        MODE_PERIOD = 2'd1,
        MODE_PRESET = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD_SECONDS = 2'd0,
        REG_PULSES_PER_KWH = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_OUTER = 2'd0,
        DIV_INNER = 2'd1,
        DIV_WATT  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     pulse;
        logic     preset;
        logic     period_end;
        logic     div_start;
        div_sel_t div_sel;
        logic     save_outer;
        logic     watts_max;
        logic     watts_load;
        logic     out_load;
    } pem_cmd_t;

    typedef struct packed {
        logic p_zero;
        logic secs_zero;
        logic div_busy;
        logic div_done;
        logic quo_zero;
    } pem_status_t;

endpackage

/* sv/pem_div.sv */
module pem_div #(
    parameter int DW = pem_pkg::DIV_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          busy,
    output logic          done
);

    // two restoring steps per cycle
    localparam int STEPS = (DW + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [QW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   r1, r1s, r2, r2s;
    logic          ge1, ge2;

    always_comb begin
        r1       = {rem_reg, q_reg[QW-1]};
        ge1      = r1 >= {1'b0, d_reg};
        r1s      = ge1 ? r1 - {1'b0, d_reg} : r1;
        r2       = {r1s[DW-1:0], q_reg[QW-2]};
        ge2      = r2 >= {1'b0, d_reg};
        r2s      = ge2 ? r2 - {1'b0, d_reg} : r2;
        rem_next = r2s[DW-1:0];
        q_next   = {q_reg[QW-3:0], ge1, ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            q_reg   <= QW'(dividend);
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = q_reg[DW-1:0];
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

/* sv/pem_datapath.sv */
module pem_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_write,
    input  logic [pem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pem_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [pem_pkg::KWH_W-1:0]        preset_value,
    input  pem_pkg::pem_cmd_t                cmd,
    output pem_pkg::pem_status_t             status,
    output logic [pem_pkg::KWH_W-1:0]        energy_kwh,
    output logic [pem_pkg::FRAC_W-1:0]       pulse_fraction,
    output logic [pem_pkg::WATTS_W-1:0]      power_watts,
    output logic                             sensor_fail
);

    logic [pem_pkg::SECS_W-1:0]   secs_reg;
    logic [pem_pkg::PPK_W-1:0]    ppk_reg;
    logic [pem_pkg::KWH_W-1:0]    kwh_reg, kwh_next;
    logic [pem_pkg::FRAC_W-1:0]   frac_reg, frac_next, frac_inc;
    logic [pem_pkg::PPER_W-1:0]   pper_reg, pper_next, p_reg;
    logic [pem_pkg::WATTS_W-1:0]  watts_reg, watts_next;
    logic [pem_pkg::SILENT_W-1:0] silent_reg, silent_next;
    logic [pem_pkg::DIV_W-1:0]    outer_reg;

    logic [pem_pkg::KWH_W-1:0]    out_kwh_reg;
    logic [pem_pkg::FRAC_W-1:0]   out_frac_reg;
    logic [pem_pkg::WATTS_W-1:0]  out_watts_reg;
    logic                         out_fail_reg;

    logic [pem_pkg::DIV_W-1:0]    div_dividend, div_divisor, div_quotient;
    logic                         div_busy, div_done;

    pem_div #(
        .DW (pem_pkg::DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_comb begin
        case (cmd.div_sel)
            pem_pkg::DIV_OUTER: begin
                div_dividend = pem_pkg::WATT_SEC_PER_KWH;
                div_divisor  = pem_pkg::DIV_W'(secs_reg);
            end
            pem_pkg::DIV_INNER: begin
                div_dividend = pem_pkg::DIV_W'(ppk_reg);
                div_divisor  = pem_pkg::DIV_W'(p_reg);
            end
            pem_pkg::DIV_WATT: begin
                // divisor is the inner quotient still held by the divider
                div_dividend = outer_reg;
                div_divisor  = div_quotient;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    always_comb begin
        kwh_next    = kwh_reg;
        frac_next   = frac_reg;
        pper_next   = pper_reg;
        watts_next  = watts_reg;
        silent_next = silent_reg;
        frac_inc    = frac_reg + 1'b1;

        if (cmd.pulse) begin
            if (pper_reg != pem_pkg::PERIOD_PULSES_MAX)
                pper_next = pper_reg + 1'b1;
            if (frac_inc >= ppk_reg) begin
                kwh_next  = kwh_reg + 1'b1;
                frac_next = '0;
            end else begin
                frac_next = frac_inc;
            end
        end
        if (cmd.preset)
            kwh_next = preset_value;
        if (cmd.period_end) begin
            pper_next = '0;
            if (pper_reg != '0)
                silent_next = '0;
            else if (silent_reg != pem_pkg::SILENT_MAX)
                silent_next = silent_reg + 1'b1;
        end
        if (cmd.watts_max)
            watts_next = pem_pkg::WATTS_MAX;
        else if (cmd.watts_load)
            watts_next = pem_pkg::WATTS_W'(div_quotient);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secs_reg   <= pem_pkg::SECS_RESET;
            ppk_reg    <= pem_pkg::PPK_RESET;
            kwh_reg    <= '0;
            frac_reg   <= '0;
            pper_reg   <= '0;
            watts_reg  <= '0;
            silent_reg <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    pem_pkg::REG_PERIOD_SECONDS: secs_reg <= cfg_data[pem_pkg::SECS_W-1:0];
                    pem_pkg::REG_PULSES_PER_KWH: ppk_reg  <= cfg_data[pem_pkg::PPK_W-1:0];
                    default: ;
                endcase
            end
            kwh_reg    <= kwh_next;
            frac_reg   <= frac_next;
            pper_reg   <= pper_next;
            watts_reg  <= watts_next;
            silent_reg <= silent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.period_end)
            p_reg <= pper_reg;
        if (cmd.save_outer)
            outer_reg <= div_quotient;
        if (cmd.out_load) begin
            out_kwh_reg   <= kwh_reg;
            out_frac_reg  <= frac_reg;
            out_watts_reg <= watts_reg;
            out_fail_reg  <= silent_reg > pem_pkg::MISS_THRESHOLD;
        end
    end

    assign status.p_zero    = pper_reg == '0;
    assign status.secs_zero = secs_reg == '0;
    assign status.div_busy  = div_busy;
    assign status.div_done  = div_done;
    assign status.quo_zero  = div_quotient == '0;

    assign energy_kwh     = out_kwh_reg;
    assign pulse_fraction = out_frac_reg;
    assign power_watts    = out_watts_reg;
    assign sensor_fail    = out_fail_reg;

endmodule

/* sv/pem_ctrl.sv */
module pem_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pem_pkg::MODE_W-1:0]   s_mode,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  pem_pkg::pem_status_t         status,
    output pem_pkg::pem_cmd_t            cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OUTER,
        S_INNER,
        S_WATT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = state_reg == S_IDLE;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd          = '0;
        cmd.div_sel  = pem_pkg::DIV_OUTER;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RESULT;
                    case (s_mode)
                        pem_pkg::MODE_PULSE:  cmd.pulse  = 1'b1;
                        pem_pkg::MODE_PRESET: cmd.preset = 1'b1;
                        pem_pkg::MODE_PERIOD: begin
                            cmd.period_end = 1'b1;
                            if (!status.p_zero) begin
                                if (status.secs_zero) begin
                                    cmd.watts_max = 1'b1;
                                end else begin
                                    cmd.div_start = 1'b1;
                                    state_next    = S_OUTER;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OUTER: begin
                if (status.div_done) begin
                    cmd.save_outer = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = pem_pkg::DIV_INNER;
                    state_next     = S_INNER;
                end
            end
            S_INNER: begin
                if (status.div_done) begin
                    if (status.quo_zero) begin
                        cmd.watts_max = 1'b1;
                        state_next    = S_RESULT;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = pem_pkg::DIV_WATT;
                        state_next    = S_WATT;
                    end
                end
            end
            S_WATT: begin
                if (status.div_done) begin
                    cmd.watts_load = 1'b1;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT: begin
                // snapshot the updated state once the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* sv/pulse_energy_meter.sv */
// pulse, preset and empty-period transactions go from acceptance straight to loading the result
// a period end with pulses and nonzero period_seconds makes up to three passes of the
//   shared 2-bit-per-cycle divider (outer, inner, final); a zero inner skips the final pass
// one transaction at a time: s_ready stays low until the result is loaded into the output
// reset: synchronous active-low aresetn clears all counters and totals, watts to 0,
//   and loads period_seconds 30 and pulses_per_kwh 10000; no clearing pass
module pulse_energy_meter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pem_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pem_pkg::MODE_W-1:0]       s_mode,
    input  logic [pem_pkg::KWH_W-1:0]        s_preset_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pem_pkg::KWH_W-1:0]        m_energy_kwh,
    output logic [pem_pkg::FRAC_W-1:0]       m_pulse_fraction,
    output logic [pem_pkg::WATTS_W-1:0]      m_power_watts,
    output logic                             m_sensor_fail
);

    pem_pkg::pem_cmd_t    cmd;
    pem_pkg::pem_status_t status;

    assign cfg_ready = 1'b1;

    pem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pem_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .preset_value   (s_preset_value),
        .cmd            (cmd),
        .status         (status),
        .energy_kwh     (m_energy_kwh),
        .pulse_fraction (m_pulse_fraction),
        .power_watts    (m_power_watts),
        .sensor_fail    (m_sensor_fail)
    );

    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_busy |-> !s_ready)
        else $error("input accepted while divider busy");

    a_start_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten before transaction taken");

    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result loaded but not presented");

endmodule
